// File: src/ggc_pkg.sv
// ----------------------------------------------------------------------------
// Greedy graph coloring package
// Field widths and the result record shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package ggc_pkg;

	localparam int NBR_W   = 10;
	localparam int VIDX_W  = 10;
	localparam int COLOR_W = 6;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [VIDX_W-1:0]  vertex_index;
		logic [COLOR_W-1:0] vertex_color;
		logic [COUNT_W-1:0] colors_in_use;
		logic               overflow;
	} result_t;

endpackage

// File: src/ggc_if.sv
// ----------------------------------------------------------------------------
// Greedy graph coloring channels
// Valid/ready channels for neighbor items and for coloring results.
// ----------------------------------------------------------------------------
interface ggc_item_if;
	logic                     valid;
	logic                     ready;
	logic                     start_graph;
	logic [ggc_pkg::NBR_W-1:0] neighbor_index;
	logic                     has_neighbor;
	logic                     last_neighbor;

	modport source (output valid, start_graph, neighbor_index, has_neighbor,
		last_neighbor, input ready);
	modport sink (input valid, start_graph, neighbor_index, has_neighbor,
		last_neighbor, output ready);
endinterface

interface ggc_result_if;
	logic                       valid;
	logic                       ready;
	logic [ggc_pkg::VIDX_W-1:0]  vertex_index;
	logic [ggc_pkg::COLOR_W-1:0] vertex_color;
	logic [ggc_pkg::COUNT_W-1:0] colors_in_use;
	logic                       overflow;

	modport source (output valid, vertex_index, vertex_color, colors_in_use,
		overflow, input ready);
	modport sink (input valid, vertex_index, vertex_color, colors_in_use,
		overflow, output ready);
endinterface

// File: src/greedy_graph_coloring_top.sv
// Takes one neighbor item per clock cycle, back to back, while the result side
// does not stall, and answers each vertex through the item stage (registered
// color table read at acceptance) and the result register (mask update with
// first-free encode). A stalled result holds the stage behind it only when that
// stage also carries a last item. After reset the color table holds nothing
// valid; only vertices colored in the current graph are looked up.
// ----------------------------------------------------------------------------
// Greedy graph coloring top level
// First-fit coloring of a streamed conflict graph, one vertex per neighbor run.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_top #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_COLORS   = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	ggc_item_if.sink     items,
	ggc_result_if.source results
);

	localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int VW   = $clog2(MAX_VERTICES + 1);
	localparam int CLW  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
	localparam int CNTW = $clog2(MAX_COLORS + 1);
	localparam int CW   = (VW > ggc_pkg::NBR_W) ? VW : ggc_pkg::NBR_W;

	// Stage 1 item and forwarding registers.
	logic                      valid_s1;
	logic                      start_s1;
	logic [ggc_pkg::NBR_W-1:0] nbr_s1;
	logic                      has_s1;
	logic                      last_s1;
	logic                      fwd_s1;
	logic [CLW-1:0]            fwd_color_s1;

	// Graph state.
	logic [VW-1:0]         vertex_q;
	logic [MAX_COLORS-1:0] mask_q;
	logic [CNTW-1:0]       count_q;

	logic            out_valid_q;
	ggc_pkg::result_t res_q;

	logic                  accept;
	logic                  s1_adv;
	logic [VW-1:0]         vert_eff;
	logic [MAX_COLORS-1:0] mask_base;
	logic [CNTW-1:0]       count_eff;
	logic [CLW-1:0]        rd_color;
	logic [CLW-1:0]        nb_color;
	logic                  nb_ok;
	logic [MAX_COLORS-1:0] mask_new;
	logic [CLW-1:0]        pick_color;
	logic                  pick_full;
	logic                  vfull;
	logic [CNTW-1:0]       count_next;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic                  commit;

	assign accept       = items.valid && items.ready;
	assign s1_adv       = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign items.ready  = !valid_s1 || s1_adv;

	// A start request clears the graph state before its own neighbor is used.
	assign vert_eff  = start_s1 ? '0 : vertex_q;
	assign mask_base = start_s1 ? '0 : mask_q;
	assign count_eff = start_s1 ? '0 : count_q;

	assign nb_color = fwd_s1 ? fwd_color_s1 : rd_color;
	assign nb_ok    = has_s1 && (CW'(nbr_s1) < CW'(vert_eff))
		&& (CW'(nbr_s1) < CW'(MAX_VERTICES));
	assign mask_new = mask_base | (nb_ok ? (MAX_COLORS'(1) << nb_color) : '0);

	ggc_pick #(
		.MAX_COLORS (MAX_COLORS),
		.CLW        (CLW)
	) u_pick (
		.mask  (mask_new),
		.color (pick_color),
		.full  (pick_full)
	);

	assign vfull  = vert_eff >= VW'(MAX_VERTICES);
	assign commit = last_s1 && !vfull;

	always_comb begin
		count_next = count_eff;
		if ((CNTW'(pick_color) >= count_eff) && (count_eff < CNTW'(MAX_COLORS))) begin
			count_next = CNTW'(pick_color) + CNTW'(1);
		end
	end

	assign wr_en   = s1_adv && commit;
	assign wr_addr = AW'(vert_eff);

	ggc_color_mem #(
		.DEPTH (MAX_VERTICES),
		.AW    (AW),
		.DW    (CLW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (pick_color),
		.rd_en   (accept),
		.rd_addr (AW'(items.neighbor_index)),
		.rd_data (rd_color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// A vertex written in the same cycle as the read is taken from the write side.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1     <= items.start_graph;
			nbr_s1       <= items.neighbor_index;
			has_s1       <= items.has_neighbor;
			last_s1      <= items.last_neighbor;
			fwd_s1       <= wr_en && (wr_addr == AW'(items.neighbor_index));
			fwd_color_s1 <= pick_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_q <= '0;
			mask_q   <= '0;
			count_q  <= '0;
		end else if (s1_adv) begin
			mask_q   <= last_s1 ? '0 : mask_new;
			vertex_q <= commit ? vert_eff + VW'(1) : vert_eff;
			count_q  <= commit ? count_next : count_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			res_q.vertex_index  <= vfull ? ggc_pkg::VIDX_W'(MAX_VERTICES - 1)
				: ggc_pkg::VIDX_W'(vert_eff);
			res_q.vertex_color  <= vfull ? '0 : ggc_pkg::COLOR_W'(pick_color);
			res_q.colors_in_use <= vfull ? ggc_pkg::COUNT_W'(count_eff)
				: ggc_pkg::COUNT_W'(count_next);
			res_q.overflow      <= vfull || pick_full;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.vertex_index  = res_q.vertex_index;
	assign results.vertex_color  = res_q.vertex_color;
	assign results.colors_in_use = res_q.colors_in_use;
	assign results.overflow      = res_q.overflow;

endmodule

// File: src/ggc_color_mem.sv
// ----------------------------------------------------------------------------
// Color table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ggc_color_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read at the address being written returns the old entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/ggc_pick.sv
// ----------------------------------------------------------------------------
// First free color
// Lowest clear bit of the used-color mask, saturating when the mask is full.
// ----------------------------------------------------------------------------
module ggc_pick #(
	parameter int MAX_COLORS = 64,
	parameter int CLW        = 6
) (
	input  logic [MAX_COLORS-1:0] mask,
	output logic [CLW-1:0]        color,
	output logic                  full
);

	logic [MAX_COLORS-1:0] free;
	logic [MAX_COLORS-1:0] lowest;
	logic [CLW-1:0]        idx;

	assign free   = ~mask;
	assign lowest = free & (~free + MAX_COLORS'(1));
	assign full   = ~|free;

	always_comb begin
		idx = '0;
		for (int i = 0; i < MAX_COLORS; i++) begin
			if (lowest[i]) begin
				idx = idx | CLW'(i);
			end
		end
	end

	assign color = full ? CLW'(MAX_COLORS - 1) : idx;

endmodule

// File: src/ggc_checker.sv
// ----------------------------------------------------------------------------
// Greedy graph coloring checker
// Port-level assertions on the result and item channels, bound to the top level.
// ----------------------------------------------------------------------------
module ggc_checker #(
	parameter int MAX_COLORS = 64
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_last,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [ggc_pkg::VIDX_W-1:0]  out_vertex,
	input logic [ggc_pkg::COLOR_W-1:0] out_color,
	input logic [ggc_pkg::COUNT_W-1:0] out_count,
	input logic                        out_overflow
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_vertex) && $stable(out_color)
			&& $stable(out_count) && $stable(out_overflow))
		else $error("stalled result request changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count != '0
			&& out_count <= ggc_pkg::COUNT_W'(MAX_COLORS)
			&& ggc_pkg::COUNT_W'(out_color) < out_count)
		else $error("color or color count out of range");

	// A new result can only follow the acceptance of a last neighbor item, which
	// passes through the item stage and the result register first.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("result without a last neighbor request");

endmodule

bind greedy_graph_coloring_top ggc_checker #(
	.MAX_COLORS (MAX_COLORS)
) u_ggc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (items.valid),
	.in_ready     (items.ready),
	.in_last      (items.last_neighbor),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_vertex   (results.vertex_index),
	.out_color    (results.vertex_color),
	.out_count    (results.colors_in_use),
	.out_overflow (results.overflow)
);

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy graph coloring testbench
// Streams neighbor runs into the coloring block and checks every vertex result
// against a first-fit predictor kept alongside. A short table of hand-written
// requests opens the run. Random graphs follow under four idling mixes, with a
// long result stall and a 16-vertex clique that climbs through the colors.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_VERTICES = 1024;
	localparam int MAX_COLORS   = 64;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic                      first;
		logic [ggc_pkg::NBR_W-1:0] nb;
		logic                      has;
		logic                      last;
		logic                      typed;
		ggc_pkg::result_t          want;
	} dir_row_t;

	// Rows with typed set carry a result that can be read straight off the rules.
	localparam dir_row_t DIRECTED [0:20] = '{
		'{1'b1, 10'd0,    1'b0, 1'b1, 1'b1, '{10'd0, 6'd0, 7'd1, 1'b0}},
		'{1'b0, 10'd0,    1'b1, 1'b1, 1'b1, '{10'd1, 6'd1, 7'd2, 1'b0}},
		'{1'b0, 10'd1023, 1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 10'd1,    1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    1'b1, 1'b1, 1'b1, '{10'd2, 6'd2, 7'd3, 1'b0}},
		'{1'b0, 10'd2,    1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 10'd1023, 1'b0, 1'b0, 1'b0, '0},
		'{1'b0, 10'd3,    1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 10'd2,    1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 10'd4,    1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    1'b1, 1'b0, 1'b0, '0},
		'{1'b1, 10'd0,    1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 10'h2AA,  1'b0, 1'b1, 1'b1, '{10'd0, 6'd0, 7'd1, 1'b0}},
		'{1'b0, 10'd0,    1'b1, 1'b1, 1'b1, '{10'd1, 6'd1, 7'd2, 1'b0}},
		'{1'b1, 10'd1023, 1'b1, 1'b1, 1'b1, '{10'd0, 6'd0, 7'd1, 1'b0}},
		'{1'b1, 10'h155,  1'b0, 1'b1, 1'b1, '{10'd0, 6'd0, 7'd1, 1'b0}},
		'{1'b0, 10'd0,    1'b1, 1'b1, 1'b1, '{10'd1, 6'd1, 7'd2, 1'b0}},
		'{1'b0, 10'd1,    1'b1, 1'b0, 1'b0, '0},
		'{1'b0, 10'd1,    1'b1, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    1'b0, 1'b0, 1'b0, '0},
		'{1'b0, 10'd512,  1'b1, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	ggc_item_if   nbr_if ();
	ggc_result_if res_if ();

	greedy_graph_coloring_top #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_COLORS(MAX_COLORS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(nbr_if),
		.results(res_if)
	);

	// Predictor state: one first-fit coloring in progress.
	logic [ggc_pkg::COLOR_W-1:0] color_of [0:MAX_VERTICES-1];
	int unsigned                 vtx_now;
	bit [63:0]                   taken_colors;
	int unsigned                 colors_used;

	ggc_pkg::result_t coloring_q [$];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int items_sent;
	int graphs_sent;
	int results_seen;
	int bad_count;
	int cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit first_fit_color(input logic first,
		input logic [ggc_pkg::NBR_W-1:0] nb, input logic has, input logic last,
		output ggc_pkg::result_t res);
		int pick;
		bit full;
		res = '0;
		if (first) begin
			vtx_now = 0;
			taken_colors = '0;
			colors_used = 0;
		end
		if (has && nb < vtx_now)
			taken_colors[color_of[nb]] = 1'b1;
		if (!last)
			return 1'b0;
		if (vtx_now >= MAX_VERTICES) begin
			res.vertex_index  = ggc_pkg::VIDX_W'(MAX_VERTICES - 1);
			res.vertex_color  = '0;
			res.colors_in_use = ggc_pkg::COUNT_W'(colors_used);
			res.overflow      = 1'b1;
		end else begin
			full = 1'b1;
			pick = MAX_COLORS - 1;
			for (int i = MAX_COLORS - 1; i >= 0; i--) begin
				if (!taken_colors[i]) begin
					pick = i;
					full = 1'b0;
				end
			end
			color_of[vtx_now] = ggc_pkg::COLOR_W'(pick);
			if (pick >= colors_used && colors_used < MAX_COLORS)
				colors_used = pick + 1;
			res.vertex_index  = ggc_pkg::VIDX_W'(vtx_now);
			res.vertex_color  = ggc_pkg::COLOR_W'(pick);
			res.colors_in_use = ggc_pkg::COUNT_W'(colors_used);
			res.overflow      = full;
			vtx_now++;
		end
		taken_colors = '0;
		return 1'b1;
	endfunction

	task automatic flag_error(input string what, input ggc_pkg::result_t want,
		input ggc_pkg::result_t got);
		bad_count++;
		if (bad_count <= 10) begin
			$display("%0t: %s: expected vertex %0d color %0d count %0d ovf %0b,",
				$time, what, want.vertex_index, want.vertex_color, want.colors_in_use,
				want.overflow);
			$display("    got vertex %0d color %0d count %0d ovf %0b",
				got.vertex_index, got.vertex_color, got.colors_in_use, got.overflow);
		end
	endtask

	// Offers one request and waits for it to be taken; the prediction is made at
	// the accepting edge, before its result can be accepted.
	task automatic offer_neighbor(input logic first, input logic [ggc_pkg::NBR_W-1:0] nb,
		input logic has, input logic last, input logic typed = 1'b0,
		input ggc_pkg::result_t want = '0);
		ggc_pkg::result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			nbr_if.valid <= 1'b0;
			@(posedge clk);
		end
		nbr_if.valid          <= 1'b1;
		nbr_if.start_graph    <= first;
		nbr_if.neighbor_index <= nb;
		nbr_if.has_neighbor   <= has;
		nbr_if.last_neighbor  <= last;
		@(posedge clk);
		while (!nbr_if.ready)
			@(posedge clk);
		if (first_fit_color(first, nb, has, last, predicted))
			coloring_q.insert(coloring_q.size(), typed ? want : predicted);
		items_sent++;
		if (first)
			graphs_sent++;
	endtask

	// A graph of random size with vertices in order; most neighbors sit just
	// below the vertex so that colors climb, a few are out of reach, and now and
	// then an empty request or a dropped vertex is mixed in.
	task automatic random_graph(input int max_vtx, input int max_nbr);
		int n_vtx;
		int n_nbr;
		int roll;
		logic [ggc_pkg::NBR_W-1:0] nb;
		logic first;
		n_vtx = $urandom_range(1, max_vtx);
		first = 1'b1;
		for (int k = 0; k < n_vtx; k++) begin
			n_nbr = (k == 0) ? 0 : $urandom_range(0, max_nbr);
			if (k > 0 && $urandom_range(0, 99) < 3) begin
				offer_neighbor(first, ggc_pkg::NBR_W'($urandom_range(0, k - 1)), 1'b1, 1'b0);
				return;
			end
			if (n_nbr == 0) begin
				offer_neighbor(first, ggc_pkg::NBR_W'($urandom), 1'b0, 1'b1);
				first = 1'b0;
			end
			for (int j = 0; j < n_nbr; j++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					nb = ggc_pkg::NBR_W'(k - 1 - $urandom_range(0, (k > 8) ? 7 : k - 1));
				else if (roll < 88)
					nb = ggc_pkg::NBR_W'($urandom_range(0, k - 1));
				else
					nb = ggc_pkg::NBR_W'($urandom_range(k, MAX_VERTICES - 1));
				if ($urandom_range(0, 99) < 5) begin
					offer_neighbor(first, ggc_pkg::NBR_W'($urandom), 1'b0, 1'b0);
					first = 1'b0;
				end
				offer_neighbor(first, nb, 1'b1, j == n_nbr - 1);
				first = 1'b0;
			end
		end
	endtask

	task automatic random_phase(input int n_items);
		int goal;
		goal = items_sent + n_items;
		while (items_sent < goal)
			random_graph(16, 6);
	endtask

	// Every vertex sees all earlier ones, so each one takes a new color.
	task automatic clique_graph(input int n_vtx);
		offer_neighbor(1'b1, '0, 1'b0, 1'b1);
		for (int k = 1; k < n_vtx; k++)
			for (int j = 0; j < k; j++)
				offer_neighbor(1'b0, ggc_pkg::NBR_W'(j), 1'b1, j == k - 1);
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		ggc_pkg::result_t got;
		ggc_pkg::result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{res_if.vertex_index, res_if.vertex_color, res_if.colors_in_use,
				res_if.overflow};
			results_seen++;
			if (coloring_q.size() == 0) begin
				flag_error("result with nothing expected", '0, got);
			end else begin
				want = coloring_q.pop_front();
				if (got.vertex_index !== want.vertex_index ||
					got.vertex_color !== want.vertex_color ||
					got.colors_in_use !== want.colors_in_use ||
					got.overflow !== want.overflow)
					flag_error("result mismatch", want, got);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding", cycle_cnt,
			coloring_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		graphs_sent = 0;
		results_seen = 0;
		bad_count = 0;
		vtx_now = 0;
		taken_colors = '0;
		colors_used = 0;
		nbr_if.valid          <= 1'b0;
		nbr_if.start_graph    <= 1'b0;
		nbr_if.neighbor_index <= '0;
		nbr_if.has_neighbor   <= 1'b0;
		nbr_if.last_neighbor  <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer_neighbor(DIRECTED[i].first, DIRECTED[i].nb, DIRECTED[i].has,
				DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);

		// Back to back in both directions, then a long result stall while a
		// stream of one-request vertices keeps coming.
		random_phase(90);
		hold_request = 1'b1;
		offer_neighbor(1'b1, '0, 1'b0, 1'b1);
		for (int k = 1; k < 60; k++)
			offer_neighbor(1'b0, ggc_pkg::NBR_W'(k - 1), 1'b1, 1'b1);
		clique_graph(16);

		send_idle_pct = 88;
		random_phase(90);
		send_idle_pct = 0;
		recv_stall_pct = 88;
		random_phase(90);
		send_idle_pct = 14;
		recv_stall_pct = 14;
		random_phase(90);

		nbr_if.valid <= 1'b0;
		recv_stall_pct = 0;
		while (coloring_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (coloring_q.size() != 0) begin
			bad_count += coloring_q.size();
			$display("%0d expected results never arrived", coloring_q.size());
		end

		$display("Colored %0d vertices from %0d neighbor requests over %0d graphs,",
			results_seen, items_sent, graphs_sent);
		$display("with a 16-vertex clique and a long result stall; %0d errors.",
			bad_count);
		if (bad_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
